>>> hw/rtl/fts_pkg.sv
// Shared types and constants for the frame time smoother.
package fts_pkg;

    localparam int COUNTER_W   = 64;
    localparam int INTERVAL_W  = 40;
    localparam int HELD_W      = 6;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 64;

    localparam logic [INTERVAL_W-1:0] SPIKE_LIMIT_RESET = 40'd10000000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX      = {INTERVAL_W{1'b1}};

    // Register index, taken from the 8-byte aligned address.
    localparam logic REG_SPIKE_LIMIT = 1'b0;

    typedef struct packed {
        logic rd;
        logic sub;
        logic add;
    } t_win_ctrl;

endpackage

>>> hw/rtl/fts_apb_regs.sv
// APB configuration register holding the spike limit.
module fts_apb_regs
    import fts_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,
    output logic [INTERVAL_W-1:0]       o_spike_limit
);

    logic [INTERVAL_W-1:0] r_spike_limit;
    logic                  w_hit;

    assign w_hit  = (paddr[APB_ADDR_W-1] == REG_SPIKE_LIMIT);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spike_limit <= SPIKE_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_spike_limit <= pwdata[INTERVAL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = APB_DATA_W'(r_spike_limit);
        end
    end

    assign o_spike_limit = r_spike_limit;

endmodule

>>> hw/rtl/fts_window.sv
// Sample window memory with running sum, fill count and write slot.
module fts_window
    import fts_pkg::*;
#(
    parameter int WINDOW_SIZE = 50
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_win_ctrl             i_ctrl,
    input  logic [INTERVAL_W-1:0] i_interval,
    output logic [INTERVAL_W+$clog2(WINDOW_SIZE+1)-1:0] o_sum,
    output logic [$clog2(WINDOW_SIZE+1)-1:0]            o_count
);

    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = INTERVAL_W + CNT_W;
    localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(WINDOW_SIZE);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW_SIZE - 1);

    logic [INTERVAL_W-1:0] mem [WINDOW_SIZE];
    logic [INTERVAL_W-1:0] r_rd_data;
    logic [SUM_W-1:0]      r_sum;
    logic [CNT_W-1:0]      r_count;
    logic [SLOT_W-1:0]     r_slot;
    logic                  w_full;

    assign w_full = (r_count == FULL_COUNT);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd) begin
            r_rd_data <= mem[r_slot];
        end
        if (i_ctrl.add) begin
            mem[r_slot] <= i_interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_slot  <= '0;
        end else if (i_ctrl.sub) begin
            if (w_full) begin
                r_sum <= r_sum - SUM_W'(r_rd_data);
            end
        end else if (i_ctrl.add) begin
            r_sum <= r_sum + SUM_W'(i_interval);
            if (!w_full) begin
                r_count <= r_count + 1'b1;
            end
            r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule

>>> hw/rtl/fts_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module fts_divider #(
    parameter int DIVIDEND_W = 46,
    parameter int DIVISOR_W  = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [STEP_W-1:0]     r_step;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    w_shifted;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fits;

    assign w_shifted = {r_rem, r_quot[DIVIDEND_W-1]};
    assign w_fits    = (w_shifted >= {1'b0, r_divisor});
    assign w_diff    = w_shifted - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIVIDEND_W-2:0], w_fits};
            r_rem  <= w_fits ? w_diff[DIVISOR_W-1:0] : w_shifted[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

>>> hw/rtl/frame_time_smoother.sv
// Top level of the frame time smoother: sequencer, interval path and result register.
//
// Input channel: one free-running counter reading per transfer (i_valid/o_ready).
// Output channel: one result per reading (o_valid/i_ready): the truncated mean of
// the accepted intervals in the window, whether this interval entered the window,
// and the number of intervals held.
// Configuration: APB register 0 at byte address 0 holds the spike limit in ticks.
// The block works on one reading at a time. A rejected interval goes from the test
// state straight to the output register; an accepted one passes the subtract, add,
// start and divide states, where the bit-serial divider that forms the mean
// produces one quotient bit per cycle over the width of the running sum.
// The window is a single-port memory, read when a reading is taken, before the update.
// A new reading is taken as soon as the result is in the output register, even
// while the receiver stalls; the sequencer then waits only if a second result
// is ready before the first has been taken.
// Reset clears the sum, count, slot, average, previous reading and start flag,
// and restores the spike limit to 10000000; window memory contents are not
// cleared, as a slot's old value is only used once every slot has been written.
module frame_time_smoother
    import fts_pkg::*;
#(
    parameter int WINDOW_SIZE = 50
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [COUNTER_W-1:0]    i_counter_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [INTERVAL_W-1:0]   o_average_ticks,
    output logic                    o_sample_accepted,
    output logic [HELD_W-1:0]       o_samples_held,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W = INTERVAL_W + CNT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TEST  = 3'd1;
    localparam logic [2:0] S_SUB   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [COUNTER_W-1:0]  r_prev;
    logic                  r_started;
    logic [INTERVAL_W-1:0] r_interval;
    logic [INTERVAL_W-1:0] r_avg;
    logic                  r_accept;
    logic                  r_out_valid;
    logic [INTERVAL_W-1:0] r_out_avg;
    logic                  r_out_acc;
    logic [HELD_W-1:0]     r_out_held;

    logic                  w_in_xfer;
    logic                  w_out_load;
    logic [COUNTER_W-1:0]  w_diff;
    logic [INTERVAL_W-1:0] w_interval;
    logic [INTERVAL_W-1:0] w_dev;
    logic                  w_pass;
    logic [INTERVAL_W-1:0] w_spike_limit;
    logic [SUM_W-1:0]      w_sum;
    logic [CNT_W-1:0]      w_count;
    logic                  w_div_done;
    logic [SUM_W-1:0]      w_quot;
    t_win_ctrl             w_win_ctrl;

    fts_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_spike_limit (w_spike_limit)
    );

    fts_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_win_ctrl),
        .i_interval (r_interval),
        .o_sum      (w_sum),
        .o_count    (w_count)
    );

    fts_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (w_sum),
        .i_divisor  (w_count),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign w_in_xfer = i_valid && o_ready;

    assign w_diff     = i_counter_value - r_prev;
    assign w_interval = !r_started ? '0 :
                        (w_diff[COUNTER_W-1:INTERVAL_W] != '0) ? INTERVAL_MAX :
                        w_diff[INTERVAL_W-1:0];

    assign w_dev  = (r_interval >= r_avg) ? r_interval - r_avg : r_avg - r_interval;
    assign w_pass = (w_dev < w_spike_limit);

    assign w_win_ctrl.rd  = w_in_xfer;
    assign w_win_ctrl.sub = (r_state == S_SUB);
    assign w_win_ctrl.add = (r_state == S_ADD);

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = S_TEST;
            S_TEST:  n_state = w_pass ? S_SUB : S_OUT;
            S_SUB:   n_state = S_ADD;
            S_ADD:   n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (w_div_done) n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_started   <= 1'b0;
            r_avg       <= '0;
            r_accept    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                r_prev    <= i_counter_value;
                r_started <= 1'b1;
            end
            if (r_state == S_TEST) begin
                r_accept <= w_pass;
            end
            if ((r_state == S_DIV) && w_div_done) begin
                r_avg <= w_quot[INTERVAL_W-1:0];
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_interval <= w_interval;
        end
        if (w_out_load) begin
            r_out_avg  <= r_avg;
            r_out_acc  <= r_accept;
            r_out_held <= HELD_W'(w_count);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_average_ticks   = r_out_avg;
    assign o_sample_accepted = r_out_acc;
    assign o_samples_held    = r_out_held;

endmodule

>>> hw/rtl/fts_checker.sv
// Port-level checks for the frame time smoother, bound to the top level.
module fts_checker
    import fts_pkg::*;
#(
    parameter int WINDOW_SIZE = 50
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [INTERVAL_W-1:0] o_average_ticks,
    input logic                  o_sample_accepted,
    input logic [HELD_W-1:0]     o_samples_held
);

    localparam bit HELD_EXACT = (WINDOW_SIZE < (1 << HELD_W));

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("result or busy state survived reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second reading taken while one is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_average_ticks)
            && $stable(o_sample_accepted) && $stable(o_samples_held)))
        else $error("stalled result changed");

    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (HELD_EXACT && o_valid && (o_samples_held == '0))
            |-> (!o_sample_accepted && (o_average_ticks == '0)))
        else $error("empty window reports a sample or a mean");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (HELD_EXACT && o_valid) |-> (o_samples_held <= HELD_W'(WINDOW_SIZE)))
        else $error("sample count beyond window size");

endmodule

bind frame_time_smoother fts_checker #(.WINDOW_SIZE(WINDOW_SIZE)) u_fts_checker (.*);
